// ----- sv/route_property_concatenation_macros.svh -----
// ---------------------------------------------------------------------------
// route property concatenation assertion macros
// concurrent checks that vanish when synthesising
// ---------------------------------------------------------------------------
`ifndef ROUTE_PROPERTY_CONCATENATION_MACROS_SVH
`define ROUTE_PROPERTY_CONCATENATION_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define RPC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rpc assertion failed");
// next-cycle implication, disabled in reset
`define RPC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rpc assertion failed");
`else
`define RPC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RPC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- sv/rpc_pkg.sv -----
// ---------------------------------------------------------------------------
// rpc_pkg
// shared types and constants for route property concatenation
// ---------------------------------------------------------------------------
package rpc_pkg;

  localparam int ACC_WIDTH_DEF = 32;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam logic [23:0] MAX_RANGE_RST = 24'hFFFFFF;

  // register index, taken from paddr word bit
  typedef enum logic {
    REG_MAX_RANGE = 1'b0,
    REG_PREPEND   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] max_range;
    logic        prepend_mode;
  } cfg_t;

  typedef struct packed {
    logic        restart;
    logic [15:0] node_early;
    logic [15:0] node_late;
    logic        node_is_charger;
    logic [15:0] travel_time;
    logic [23:0] travel_dist;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] duration;
    logic signed [31:0] tw_violation;
    logic signed [31:0] earliest_start;
    logic signed [31:0] latest_start;
    logic signed [31:0] waiting_time;
    logic               has_charger;
    logic signed [31:0] dist_before_charger;
    logic signed [31:0] dist_after_charger;
    logic signed [31:0] energy_excess;
  } out_item_t;

endpackage

// ----- sv/rpc_cfg.sv -----
// ---------------------------------------------------------------------------
// rpc_cfg
// apb register file: vehicle range and concatenation direction
// ---------------------------------------------------------------------------
module rpc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rpc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rpc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rpc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output rpc_pkg::cfg_t                  cfg
);
  import rpc_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_MAX_RANGE: cfg_nxt.max_range    = pwdata[23:0];
        REG_PREPEND:   cfg_nxt.prepend_mode = pwdata[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAX_RANGE: prdata = {8'd0, cfg_r.max_range};
      REG_PREPEND:   prdata = {31'd0, cfg_r.prepend_mode};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_range    <= MAX_RANGE_RST;
      cfg_r.prepend_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/route_property_concatenation.sv -----
// ---------------------------------------------------------------------------
// route_property_concatenation
// folds a stream of route stops into a time-window and range sequence property
// ---------------------------------------------------------------------------
// Takes one stop per clock while in_stall is low and returns one result
// word per stop: the sequence property after that stop has been appended
// (prepend_mode 0) or prepended (prepend_mode 1), or the stop's own
// property on a restart word. Sustained rate is one stop per cycle while
// out_stall is low. A stop accepted into the input register is joined and
// written to the result register, or to the skid register while the result
// register is held, and out_valid is registered. The one-per-cycle rate is
// set by the accumulator feedback: the join of the held property with the
// incoming stop is a few adds, a signed max, a signed min and clamps at
// zero, all combinational between the input register and the accumulator.
// A two-entry output stage (result register plus skid register) keeps
// input flowing while a result waits on out_stall; in_stall rises only
// while a stop is held and both output entries are full. Accumulators are
// ACC_WIDTH bit two's complement and wrap; outputs show the low 32 bits,
// sign-extended where ACC_WIDTH is narrower. Registers: max_range at byte
// address 0, prepend_mode at 4; write them only while the block is idle.
module route_property_concatenation #(
  parameter int ACC_WIDTH = rpc_pkg::ACC_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // stop input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rpc_pkg::in_item_t              in_data,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output rpc_pkg::out_item_t             out_data,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rpc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rpc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rpc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rpc_pkg::*;
  `include "route_property_concatenation_macros.svh"

  localparam int AW = ACC_WIDTH;

  // sequence property at accumulator width
  typedef struct packed {
    logic signed [AW-1:0] dur;
    logic signed [AW-1:0] tw;
    logic signed [AW-1:0] e;
    logic signed [AW-1:0] l;
    logic signed [AW-1:0] wt;
    logic signed [AW-1:0] yp;
    logic signed [AW-1:0] yr;
    logic signed [AW-1:0] ey;
    logic                 f;
  } prop_t;

  // unsigned field into the accumulator width (wraps when narrower)
  function automatic logic signed [AW-1:0] to_acc(input logic [23:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[AW-1:0];
  endfunction

  // low 32 bits of the sign-extended accumulator
  function automatic logic signed [31:0] to_out(input logic signed [AW-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  function automatic logic signed [AW-1:0] max0(input logic signed [AW-1:0] v);
    return v[AW-1] ? '0 : v;
  endfunction

  // ---- configuration ------------------------------------------------------
  cfg_t cfg;

  rpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---- pipeline control ---------------------------------------------------
  in_item_t  s1_r;                 // input register
  logic      s1_v_r;
  prop_t     acc_r, acc_nxt;       // running sequence property
  out_item_t out_r, skid_r, res;
  logic      out_v_r, skid_v_r;
  logic      in_acc, adv, pop;

  // a stop moves into the accumulator whenever the skid slot is free
  assign adv      = s1_v_r & ~skid_v_r;
  assign in_stall = s1_v_r & skid_v_r;
  assign in_acc   = in_valid & ~in_stall;
  assign pop      = out_v_r & ~out_stall;

  // ---- join ---------------------------------------------------------------
  prop_t                node, pa, pb, jn;
  logic signed [AW-1:0] tt, dd, rng;
  logic signed [AW-1:0] delta, dwt, dtw, dy;
  logic signed [AW-1:0] be_d, bl_d, e_mx, l_mn;

  always_comb begin
    node    = '0;
    node.e  = to_acc({8'd0, s1_r.node_early});
    node.l  = to_acc({8'd0, s1_r.node_late});
    node.f  = s1_r.node_is_charger;
    tt      = to_acc({8'd0, s1_r.travel_time});
    dd      = to_acc(s1_r.travel_dist);
    rng     = to_acc(cfg.max_range);

    // prepend puts the stop in front of the held sequence
    pa = cfg.prepend_mode ? node  : acc_r;
    pb = cfg.prepend_mode ? acc_r : node;

    // time windows: shift of b relative to a's start, then wait or lateness
    delta = pa.dur - pa.tw + tt;
    be_d  = pb.e - delta;
    bl_d  = pb.l - delta;
    dwt   = max0(be_d - pa.l);
    dtw   = max0(pa.e + delta - pb.l);
    e_mx  = (be_d < pa.e) ? pa.e : be_d;
    l_mn  = (bl_d < pa.l) ? bl_d : pa.l;

    jn.dur = pa.dur + pb.dur + tt + dwt;
    jn.tw  = pa.tw + pb.tw + dtw;
    jn.e   = e_mx - dwt;
    jn.l   = l_mn + dtw;
    jn.wt  = pa.wt + pb.wt + dwt;

    // range: the stretch between a's last and b's first charger
    dy     = max0(pa.yr + dd + pb.yp - rng);
    jn.f   = pa.f | pb.f;
    jn.yp  = pa.f ? pa.yp : (pa.yp + dd + pb.yp - dy);
    jn.yr  = pb.f ? pb.yr : (pa.yr + dd + pb.yr - dy);
    jn.ey  = pa.ey + pb.ey + dy;

    acc_nxt = s1_r.restart ? node : jn;
  end

  always_comb begin
    res.duration            = to_out(acc_nxt.dur);
    res.tw_violation        = to_out(acc_nxt.tw);
    res.earliest_start      = to_out(acc_nxt.e);
    res.latest_start        = to_out(acc_nxt.l);
    res.waiting_time        = to_out(acc_nxt.wt);
    res.has_charger         = acc_nxt.f;
    res.dist_before_charger = to_out(acc_nxt.yp);
    res.dist_after_charger  = to_out(acc_nxt.yr);
    res.energy_excess       = to_out(acc_nxt.ey);
  end

  // ---- registers ----------------------------------------------------------
  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_data;
    end
    if (pop) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (adv) begin
        out_r <= res;
      end
    end else if (adv) begin
      if (out_v_r) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  // control state and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        acc_r <= acc_nxt;
      end
      if (pop) begin
        if (skid_v_r) begin
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= adv;
        end
      end else if (adv) begin
        if (out_v_r) begin
          skid_v_r <= 1'b1;
        end else begin
          out_v_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // ---- checks -------------------------------------------------------------
  `RPC_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_v_r, out_v_r)
  `RPC_ASSERT_NXT(a_restart_clears, clk, rst_n, adv && s1_r.restart, acc_r.dur == '0 && acc_r.tw == '0 && acc_r.ey == '0)
  `RPC_ASSERT_NXT(a_charger_sticks, clk, rst_n, adv && !s1_r.restart && acc_r.f, acc_r.f)
  `RPC_ASSERT_NXT(a_skid_refills_out, clk, rst_n, pop && skid_v_r, out_v_r && !skid_v_r)

endmodule

// ----- sim/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top: route property concatenation testbench
// ---------------------------------------------------------------------------
// Drives route stops into the block and keeps its own fold of the sequence
// property. Each accepted stop word queues the expected property, and each
// result word is checked field by field against the oldest one. A short
// directed table opens the run. Random sequences of stops follow, under
// several range and direction settings and under varying idle and stall
// pressure. Register writes are read back over the configuration port.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpc_pkg::*;

  // sequence property as the predictor holds it, 32-bit two's complement
  typedef struct {
    logic signed [31:0] dur;
    logic signed [31:0] tw;
    logic signed [31:0] e;
    logic signed [31:0] l;
    logic signed [31:0] wt;
    logic signed [31:0] yp;
    logic signed [31:0] yr;
    logic signed [31:0] ey;
    logic               f;
  } seq_prop_t;

  // one row of the directed table; want is only used when typed is set
  typedef struct {
    in_item_t  stop;
    bit        typed;
    out_item_t want;
  } stop_row_t;

  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 175;
  localparam int DIRECTED    = 16;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor copy of the registers and of the held property
  logic [23:0] range_setting   = MAX_RANGE_RST;
  logic        prepend_setting = 1'b0;
  seq_prop_t   route_state     = '{default: '0};

  // properties still owed by the block, oldest first
  out_item_t   pending_props[$];
  int          mismatches = 0;

  // idle and stall pressure in percent of cycles, set per phase
  int          idle_pct  = 0;
  int          stall_pct = 0;

  // directed stops, appended under the reset range; restart rows and the
  // step straight after reset have their result typed in
  stop_row_t directed_stops [DIRECTED] = '{
    // step before any restart joins a zero stop to the zero property
    '{'{1'b0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 24'h000000}, 1'b1,
      '{0, 0, 0, 0, 0, 1'b0, 0, 0, 0}},
    // restart at the field extremes, travel fields are ignored
    '{'{1'b1, 16'hFFFF, 16'h0000, 1'b1, 16'hFFFF, 24'hFFFFFF}, 1'b1,
      '{0, 0, 65535, 0, 0, 1'b1, 0, 0, 0}},
    '{'{1'b1, 16'h0000, 16'hFFFF, 1'b0, 16'h0000, 24'h000000}, 1'b1,
      '{0, 0, 0, 65535, 0, 1'b0, 0, 0, 0}},
    '{'{1'b0, 16'd100,  16'd200,  1'b0, 16'd50,   24'd1000},   1'b0, '0},
    // closed window after a long leg gives lateness
    '{'{1'b0, 16'h0000, 16'h0000, 1'b0, 16'hFFFF, 24'hFFFFFF}, 1'b0, '0},
    '{'{1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 24'h000000}, 1'b0, '0},
    // window closing before it opens
    '{'{1'b0, 16'd10,   16'd5,    1'b0, 16'd1,    24'hFFFFFF}, 1'b0, '0},
    '{'{1'b1, 16'h0000, 16'h0000, 1'b0, 16'h0000, 24'h000000}, 1'b1,
      '{0, 0, 0, 0, 0, 1'b0, 0, 0, 0}},
    '{'{1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 24'hFFFFFF}, 1'b0, '0},
    // two long legs past the last charger overrun the range
    '{'{1'b0, 16'h0000, 16'hFFFF, 1'b0, 16'h0000, 24'hFFFFFF}, 1'b0, '0},
    '{'{1'b0, 16'h0000, 16'hFFFF, 1'b0, 16'h0000, 24'hFFFFFF}, 1'b0, '0},
    '{'{1'b1, 16'd1234, 16'd5678, 1'b1, 16'h0000, 24'h000000}, 1'b1,
      '{0, 0, 1234, 5678, 0, 1'b1, 0, 0, 0}},
    '{'{1'b0, 16'h0000, 16'h0000, 1'b0, 16'hFFFF, 24'h000000}, 1'b0, '0},
    // early window far ahead forces waiting
    '{'{1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 24'd500},    1'b0, '0},
    '{'{1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 24'h000000}, 1'b1,
      '{0, 0, 65535, 65535, 0, 1'b0, 0, 0, 0}},
    '{'{1'b0, 16'h0000, 16'h0000, 1'b1, 16'h0000, 24'hFFFFFF}, 1'b0, '0}
  };

  route_property_concatenation i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic signed [31:0] max32(logic signed [31:0] a, logic signed [31:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic signed [31:0] min32(logic signed [31:0] a, logic signed [31:0] b);
    return (a < b) ? a : b;
  endfunction

  // joins property a in front of property b through one leg of travel
  function automatic seq_prop_t concat_props(seq_prop_t a, seq_prop_t b,
                                             logic signed [31:0] tt,
                                             logic signed [31:0] leg_dist,
                                             logic signed [31:0] reach);
    logic signed [31:0] delta;
    logic signed [31:0] wait_add;
    logic signed [31:0] late_add;
    logic signed [31:0] over;
    seq_prop_t          r;
    delta    = a.dur - a.tw + tt;
    wait_add = max32(0, b.e - delta - a.l);
    late_add = max32(0, a.e + delta - b.l);
    r.dur    = a.dur + b.dur + tt + wait_add;
    r.tw     = a.tw + b.tw + late_add;
    r.e      = max32(b.e - delta, a.e) - wait_add;
    r.l      = min32(b.l - delta, a.l) + late_add;
    r.wt     = a.wt + b.wt + wait_add;
    // range excess counted on the stretch between chargers across the join
    over     = max32(0, a.yr + leg_dist + b.yp - reach);
    r.f      = a.f | b.f;
    r.yp     = a.f ? a.yp : a.yp + leg_dist + b.yp - over;
    r.yr     = b.f ? b.yr : a.yr + leg_dist + b.yr - over;
    r.ey     = a.ey + b.ey + over;
    return r;
  endfunction

  // folds one accepted stop into the held property and returns the result
  function automatic out_item_t fold_stop(in_item_t s);
    seq_prop_t node;
    out_item_t r;
    logic signed [31:0] tt;
    logic signed [31:0] leg_dist;
    logic signed [31:0] reach;
    node     = '{default: '0};
    node.e   = $signed({16'h0000, s.node_early});
    node.l   = $signed({16'h0000, s.node_late});
    node.f   = s.node_is_charger;
    tt       = $signed({16'h0000, s.travel_time});
    leg_dist = $signed({8'h00, s.travel_dist});
    reach    = $signed({8'h00, range_setting});
    if (s.restart) begin
      route_state = node;
    end else if (prepend_setting) begin
      route_state = concat_props(node, route_state, tt, leg_dist, reach);
    end else begin
      route_state = concat_props(route_state, node, tt, leg_dist, reach);
    end
    r.duration            = route_state.dur;
    r.tw_violation        = route_state.tw;
    r.earliest_start      = route_state.e;
    r.latest_start        = route_state.l;
    r.waiting_time        = route_state.wt;
    r.has_charger         = route_state.f;
    r.dist_before_charger = route_state.yp;
    r.dist_after_charger  = route_state.yr;
    r.energy_excess       = route_state.ey;
    return r;
  endfunction

  // random stop; heavy legs push the distance sums towards wrapping
  function automatic in_item_t random_stop(bit restart, bit heavy);
    in_item_t s;
    int       pick;
    s.restart = restart;
    pick = $urandom_range(99);
    s.node_early = (pick < 10) ? 16'h0000 : (pick < 20) ? 16'hFFFF : 16'($urandom);
    // mostly a proper window, sometimes closing before it opens
    if ($urandom_range(99) < 70) begin
      s.node_late = s.node_early + 16'($urandom_range(0, 65535 - int'(s.node_early)));
    end else begin
      s.node_late = 16'($urandom);
    end
    s.node_is_charger = ($urandom_range(5) == 0);
    pick = $urandom_range(99);
    if (heavy) begin
      s.travel_time = 16'hFFFF - 16'($urandom_range(0, 63));
      s.travel_dist = 24'hFFFFFF - 24'($urandom_range(0, 255));
    end else if (pick < 50) begin
      s.travel_time = 16'($urandom_range(0, 500));
      s.travel_dist = 24'($urandom_range(0, 5000));
    end else if (pick < 85) begin
      s.travel_time = 16'($urandom);
      s.travel_dist = 24'($urandom);
    end else begin
      s.travel_time = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      s.travel_dist = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
    end
    return s;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // presents one stop word; entered and left just after a falling edge
  task automatic send_word(input in_item_t stop, input bit typed, input out_item_t want);
    out_item_t folded;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= stop;
    do @(posedge clk); while (in_stall);
    folded = fold_stop(stop);
    pending_props.insert(pending_props.size(), typed ? want : folded);
    @(negedge clk);
  endtask

  // drops valid and waits for every owed result plus the pipeline depth
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_props.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write in setup and access cycles, then read back
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] stored;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MAX_RANGE: begin
        range_setting = value[23:0];
        stored        = {8'h00, value[23:0]};
      end
      default: begin
        prepend_setting = value[0];
        stored          = {31'h0, value[0]};
      end
    endcase
    if (readback !== stored) begin
      mismatches++;
      $error("register %s: expected %0h, got %0h", idx.name(), stored, readback);
    end
  endtask

  // random sequences: a restart word then joined stops, now and then a
  // sequence that carries on without a restart
  task automatic run_sequences(input int budget);
    int sent;
    int len;
    bit fresh;
    bit heavy;
    sent = 0;
    while (sent < budget) begin
      heavy = ($urandom_range(99) < 15);
      len   = heavy ? $urandom_range(130, 250) : $urandom_range(1, 30);
      fresh = ($urandom_range(99) >= 5);
      for (int k = 0; k < len && sent < budget; k++) begin
        send_word(random_stop(k == 0 && fresh, heavy && k != 0), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // receiver pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result words are taken at the rising edge with valid high and stall low
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_props.size() == 0) begin
        mismatches++;
        $error("result word with no stop waiting for it");
      end else begin
        want = pending_props.pop_front();
        check_field("duration", want.duration, out_data.duration);
        check_field("tw_violation", want.tw_violation, out_data.tw_violation);
        check_field("earliest_start", want.earliest_start, out_data.earliest_start);
        check_field("latest_start", want.latest_start, out_data.latest_start);
        check_field("waiting_time", want.waiting_time, out_data.waiting_time);
        check_field("has_charger", {31'd0, want.has_charger},
                    {31'd0, out_data.has_charger});
        check_field("dist_before_charger", want.dist_before_charger,
                    out_data.dist_before_charger);
        check_field("dist_after_charger", want.dist_after_charger,
                    out_data.dist_after_charger);
        check_field("energy_excess", want.energy_excess, out_data.energy_excess);
      end
    end
  end

  initial begin
    logic [23:0] reach;
    logic        prepend;
    // synchronous reset, released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table under reset settings, no pressure
    foreach (directed_stops[i]) begin
      send_word(directed_stops[i].stop, directed_stops[i].typed, directed_stops[i].want);
    end
    settle();

    // random phases; range extremes and both directions, pressure cycles
    // through none, sender gaps, receiver stalls and both together
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin reach = 24'h000000;                    prepend = 1'b1; end
        1:       begin reach = 24'h000000;                    prepend = 1'b0; end
        2:       begin reach = 24'hFFFFFF;                    prepend = 1'b1; end
        3:       begin reach = 24'($urandom);                 prepend = 1'b0; end
        4:       begin reach = 24'($urandom);                 prepend = 1'b1; end
        5:       begin reach = 24'd1000;                      prepend = 1'b0; end
        6:       begin reach = 24'($urandom_range(0, 5000));  prepend = 1'b1; end
        default: begin reach = 24'hFFFFFF;                    prepend = 1'b0; end
      endcase
      // unused upper bits of the write data carry noise
      write_reg(REG_MAX_RANGE, {8'($urandom), reach});
      write_reg(REG_PREPEND, {31'($urandom), prepend});
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 77; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      run_sequences(PHASE_WORDS);
      settle();
    end

    if (mismatches == 0 && pending_props.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
